// ----- hw/rtl/chrp_pkg.sv -----
// Package for the cascaded heading and rate controller.
// Holds the sequencer state type, fixed-point constants and saturation helpers.
// Depends on nothing else.
`timescale 1ns / 1ps

package chrp_pkg;

    // Sequencer states. Each compute state may hand one product to the serial multiplier.
    typedef enum logic [4:0] {
        S_IDLE, S_UNW, S_OERR, S_OERR2, S_OCHK, S_OP, S_OD, S_OI, S_OSUM,
        S_SEL, S_IERR, S_IP, S_ID, S_II, S_IFF, S_F1, S_F2, S_OUT, S_MUL
    } t_state;

    // Configuration register indexes.
    localparam logic [2:0] REG_OUTER_KP    = 3'd0;
    localparam logic [2:0] REG_OUTER_KI    = 3'd1;
    localparam logic [2:0] REG_OUTER_KD    = 3'd2;
    localparam logic [2:0] REG_OUTER_LIMIT = 3'd3;
    localparam logic [2:0] REG_INNER_KP    = 3'd4;
    localparam logic [2:0] REG_INNER_KI    = 3'd5;
    localparam logic [2:0] REG_INNER_KD    = 3'd6;
    localparam logic [2:0] REG_INNER_LIMIT = 3'd7;

    // Q16.16 constants.
    localparam int PI_Q16       = 205887;
    localparam int TWO_PI_Q16   = 411775;
    localparam int DEADBAND_Q16 = 655;
    localparam int LPF_IN_COEF  = 42820;
    localparam int LPF_FB_COEF  = 22716;

    // Saturate a wide signed value to the signed 32-bit range.
    function automatic logic signed [31:0] sat32(input logic signed [49:0] x);
        logic signed [49:0] hi;
        logic signed [49:0] lo;
        hi = 50'sh7FFF_FFFF;
        lo = -50'sh8000_0000;
        if (x > hi) begin
            sat32 = 32'sh7FFF_FFFF;
        end else if (x < lo) begin
            sat32 = 32'sh8000_0000;
        end else begin
            sat32 = x[31:0];
        end
    endfunction

    // Clamp a wide signed value to plus or minus a 31-bit limit.
    function automatic logic signed [31:0] clamp_sym(input logic signed [49:0] x,
                                                     input logic [30:0] lim);
        logic signed [49:0] l;
        l = signed'(50'(lim));
        if (x > l) begin
            clamp_sym = 32'(l);
        end else if (x < -l) begin
            clamp_sym = 32'(-l);
        end else begin
            clamp_sym = x[31:0];
        end
    endfunction

endpackage

// ----- hw/rtl/cascaded_heading_rate_pid_core.sv -----
// Cascaded heading and yaw-rate controller, one tick per request.
// Uses chrp_pkg for the state type, constants and saturation functions.
`timescale 1ns / 1ps

// Usage
// Input channel: i_in_valid with o_in_stall; a request is taken at an edge where
// i_in_valid is high and o_in_stall is low. o_in_stall is high while a tick is
// being worked on. Output channel: o_out_valid with i_out_stall; the result
// register holds its value while the receiver stalls, and a new request is taken
// while a finished result still waits there.
// Configuration: i_cfg_valid with o_cfg_ready (always high), index and data.
// Write gains and limits only while the block is idle.
// Timing: all products go through one bit-serial 32x32 multiplier (one gain bit
// per cycle). A tick needs 10 products, or 7 when the angle error lies in the
// deadband, plus states for adds and saturation. The next request is taken on
// return to idle, so a new request waits until the previous tick is finished.
// If the receiver stalls while an earlier result still waits, the block waits
// in its output state before loading the output register.
// Reset (synchronous, active low) clears all gains, limits and loop state.
module cascaded_heading_rate_pid_core #(
    parameter int FEEDFORWARD_GAIN_Q16 = 0
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_in_valid,
    output logic               o_in_stall,
    input  logic signed [18:0] i_heading_angle,
    input  logic signed [31:0] i_gyro_rate,
    input  logic signed [31:0] i_target_angle,
    input  logic signed [31:0] i_target_shift,
    input  logic               i_acro_mode,
    input  logic signed [31:0] i_manual_rate,
    output logic               o_out_valid,
    input  logic               i_out_stall,
    output logic signed [31:0] o_drive_output,
    output logic signed [31:0] o_rate_target,
    output logic signed [31:0] o_unwrapped_angle,
    output logic               o_reference_captured,
    input  logic               i_cfg_valid,
    output logic               o_cfg_ready,
    input  logic [2:0]         i_cfg_index,
    input  logic [31:0]        i_cfg_data
);

    chrp_pkg::t_state r_st, n_st, r_ret, n_ret;

    // Configuration registers.
    logic [31:0] r_okp, r_oki, r_okd, r_ikp, r_iki, r_ikd;
    logic [30:0] r_olim, r_ilim;

    // Loop state.
    logic signed [7:0]  r_tc, n_tc;
    logic signed [18:0] r_prev_angle, n_prev_angle;
    logic signed [31:0] r_oprev, n_oprev, r_ointeg, n_ointeg, r_oout, n_oout;
    logic signed [31:0] r_iprev, n_iprev, r_iinteg, n_iinteg, r_fo, n_fo;
    logic               r_was, n_was;
    logic               r_ov, n_ov;

    // Latched request.
    logic signed [18:0] r_angle;
    logic signed [31:0] r_gyro, r_tgt, r_shift, r_manual;
    logic               r_acro;

    // Working registers.
    logic signed [31:0] r_unw, n_unw, r_ts, n_ts, r_oerr, n_oerr, r_p, n_p, r_d, n_d;
    logic signed [31:0] r_rref, n_rref, r_ierr, n_ierr;
    logic signed [48:0] r_facc, n_facc;
    logic               r_cap, n_cap, load_out;

    // Serial multiplier: gain bits shift out one per cycle.
    logic [31:0]        r_mp, n_mp;
    logic signed [31:0] r_mc, n_mc;
    logic signed [32:0] r_ah, n_ah;
    logic [31:0]        r_al, n_al;
    logic [4:0]         r_cnt, n_cnt;
    logic               mul_go;
    logic [31:0]        mul_g;
    logic signed [31:0] mul_v;
    logic signed [33:0] mul_sum;
    logic signed [63:0] w_prod;
    logic signed [31:0] w_gm;

    // Output register.
    logic signed [31:0] r_o_drive, r_o_rref, r_o_unw;
    logic               r_o_cap;

    // Scratch values.
    logic signed [19:0] delta;
    logic signed [31:0] dd, ierr_c, vi_c;
    logic signed [49:0] wide;
    logic               dead;

    assign o_in_stall           = (r_st != chrp_pkg::S_IDLE);
    assign o_out_valid          = r_ov;
    assign o_cfg_ready          = 1'b1;
    assign o_drive_output       = r_o_drive;
    assign o_rate_target        = r_o_rref;
    assign o_unwrapped_angle    = r_o_unw;
    assign o_reference_captured = r_o_cap;

    assign mul_sum = 34'(r_ah) + (r_mp[0] ? 34'(r_mc) : 34'sd0);
    assign w_prod  = signed'({r_ah[31:0], r_al});
    assign w_gm    = chrp_pkg::sat32(50'(signed'(w_prod[63:16])));

    // Sequencer: next state, loop state updates and multiplier requests.
    always_comb begin
        n_st = r_st; n_ret = r_ret;
        n_tc = r_tc; n_prev_angle = r_prev_angle;
        n_oprev = r_oprev; n_ointeg = r_ointeg; n_oout = r_oout;
        n_iprev = r_iprev; n_iinteg = r_iinteg; n_fo = r_fo; n_was = r_was;
        n_unw = r_unw; n_ts = r_ts; n_oerr = r_oerr; n_p = r_p; n_d = r_d;
        n_rref = r_rref; n_ierr = r_ierr; n_facc = r_facc; n_cap = r_cap;
        n_mp = r_mp; n_mc = r_mc; n_ah = r_ah; n_al = r_al; n_cnt = r_cnt;
        mul_go = 1'b0; mul_g = '0; mul_v = '0;
        load_out = 1'b0;
        n_ov = r_ov && i_out_stall;
        delta = 20'(r_angle) - 20'(r_prev_angle);
        dead = 1'b0;
        dd = '0; ierr_c = '0; vi_c = '0; wide = '0;
        case (r_st)
            chrp_pkg::S_IDLE: begin
                if (i_in_valid) begin
                    n_st = chrp_pkg::S_UNW;
                end
            end
            chrp_pkg::S_UNW: begin
                if (delta < -20'sd205887) begin
                    if (r_tc != 8'sd127) n_tc = r_tc + 8'sd1;
                end else if (delta > 20'sd205887) begin
                    if (r_tc != -8'sd128) n_tc = r_tc - 8'sd1;
                end
                n_prev_angle = r_angle;
                mul_go = 1'b1; mul_g = 32'(chrp_pkg::TWO_PI_Q16); mul_v = 32'(n_tc);
                n_ret = chrp_pkg::S_OERR;
            end
            chrp_pkg::S_OERR: begin
                n_unw = chrp_pkg::sat32(50'(w_prod) + 50'(r_angle));
                n_ts  = chrp_pkg::sat32(50'(r_tgt) - 50'(r_shift));
                n_st  = chrp_pkg::S_OERR2;
            end
            chrp_pkg::S_OERR2: begin
                n_oerr = chrp_pkg::sat32(50'(r_ts) - 50'(r_unw));
                n_st   = chrp_pkg::S_OCHK;
            end
            chrp_pkg::S_OCHK: begin
                dead = (r_oerr >= -32'(chrp_pkg::DEADBAND_Q16))
                    && (r_oerr <= 32'(chrp_pkg::DEADBAND_Q16));
                if (dead) begin
                    n_oprev = r_oerr;
                    n_st = chrp_pkg::S_SEL;
                end else begin
                    mul_go = 1'b1; mul_g = r_okp; mul_v = r_oerr;
                    n_ret = chrp_pkg::S_OP;
                end
            end
            chrp_pkg::S_OP: begin
                n_p = w_gm;
                dd = chrp_pkg::sat32(50'(r_oerr) - 50'(r_oprev));
                mul_go = 1'b1; mul_g = r_okd; mul_v = dd;
                n_ret = chrp_pkg::S_OD;
            end
            chrp_pkg::S_OD: begin
                n_d = w_gm;
                mul_go = 1'b1; mul_g = r_oki; mul_v = r_oerr;
                n_ret = chrp_pkg::S_OI;
            end
            chrp_pkg::S_OI: begin
                n_ointeg = chrp_pkg::sat32(50'(r_ointeg) + 50'(w_gm));
                n_st = chrp_pkg::S_OSUM;
            end
            chrp_pkg::S_OSUM: begin
                wide = 50'(r_p) + 50'(r_ointeg) + 50'(r_d);
                n_oout = chrp_pkg::clamp_sym(wide, r_olim);
                n_oprev = r_oerr;
                n_st = chrp_pkg::S_SEL;
            end
            chrp_pkg::S_SEL: begin
                n_cap = 1'b0;
                if (!r_acro) begin
                    if (r_was) begin
                        n_oout = '0; n_tc = '0; n_was = 1'b0; n_cap = 1'b1;
                        n_rref = '0;
                    end else begin
                        n_rref = r_oout;
                    end
                end else begin
                    wide = (-50'(r_manual)) >>> 1;
                    n_rref = chrp_pkg::sat32(wide);
                    n_was = 1'b1;
                end
                n_st = chrp_pkg::S_IERR;
            end
            chrp_pkg::S_IERR: begin
                ierr_c = chrp_pkg::sat32(50'(r_rref) - 50'(r_gyro));
                n_ierr = ierr_c;
                mul_go = 1'b1; mul_g = r_ikp; mul_v = ierr_c;
                n_ret = chrp_pkg::S_IP;
            end
            chrp_pkg::S_IP: begin
                n_p = w_gm;
                dd = chrp_pkg::sat32(50'(r_ierr) - 50'(r_iprev));
                mul_go = 1'b1; mul_g = r_ikd; mul_v = dd;
                n_ret = chrp_pkg::S_ID;
            end
            chrp_pkg::S_ID: begin
                n_d = w_gm;
                mul_go = 1'b1; mul_g = r_iki; mul_v = r_ierr;
                n_ret = chrp_pkg::S_II;
            end
            chrp_pkg::S_II: begin
                n_iinteg = chrp_pkg::sat32(50'(r_iinteg) + 50'(w_gm));
                mul_go = 1'b1; mul_g = 32'(FEEDFORWARD_GAIN_Q16); mul_v = r_rref;
                n_ret = chrp_pkg::S_IFF;
            end
            chrp_pkg::S_IFF: begin
                wide = 50'(r_p) + 50'(r_iinteg) + 50'(r_d) + 50'(w_gm);
                vi_c = chrp_pkg::sat32(wide);
                n_iprev = r_ierr;
                mul_go = 1'b1; mul_g = 32'(chrp_pkg::LPF_IN_COEF); mul_v = vi_c;
                n_ret = chrp_pkg::S_F1;
            end
            chrp_pkg::S_F1: begin
                n_facc = 49'(w_prod);
                mul_go = 1'b1; mul_g = 32'(chrp_pkg::LPF_FB_COEF); mul_v = r_fo;
                n_ret = chrp_pkg::S_F2;
            end
            chrp_pkg::S_F2: begin
                wide = (50'(r_facc) + 50'(w_prod)) >>> 16;
                n_fo = chrp_pkg::sat32(wide);
                n_st = chrp_pkg::S_OUT;
            end
            chrp_pkg::S_OUT: begin
                if (!r_ov || !i_out_stall) begin
                    load_out = 1'b1;
                    n_ov = 1'b1;
                    n_st = chrp_pkg::S_IDLE;
                end
            end
            chrp_pkg::S_MUL: begin
                n_ah  = mul_sum[33:1];
                n_al  = {mul_sum[0], r_al[31:1]};
                n_mp  = {1'b0, r_mp[31:1]};
                n_cnt = r_cnt + 5'd1;
                if (r_cnt == 5'd31) begin
                    n_st = r_ret;
                end
            end
            default: begin
                n_st = chrp_pkg::S_IDLE;
            end
        endcase
        // Start a product: clear the accumulator and load the operands.
        if (mul_go) begin
            n_mp = mul_g; n_mc = mul_v; n_ah = '0; n_al = '0; n_cnt = '0;
            n_st = chrp_pkg::S_MUL;
        end
    end

    // Control, configuration and loop state registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_st <= chrp_pkg::S_IDLE; r_ret <= chrp_pkg::S_IDLE;
            r_okp <= '0; r_oki <= '0; r_okd <= '0; r_olim <= '0;
            r_ikp <= '0; r_iki <= '0; r_ikd <= '0; r_ilim <= '0;
            r_tc <= '0; r_prev_angle <= '0; r_oprev <= '0; r_ointeg <= '0;
            r_oout <= '0; r_iprev <= '0; r_iinteg <= '0; r_fo <= '0;
            r_was <= 1'b0; r_ov <= 1'b0;
        end else begin
            r_st <= n_st; r_ret <= n_ret;
            r_tc <= n_tc; r_prev_angle <= n_prev_angle; r_oprev <= n_oprev;
            r_ointeg <= n_ointeg; r_oout <= n_oout; r_iprev <= n_iprev;
            r_iinteg <= n_iinteg; r_fo <= n_fo; r_was <= n_was; r_ov <= n_ov;
            if (i_cfg_valid) begin
                case (i_cfg_index)
                    chrp_pkg::REG_OUTER_KP:    r_okp  <= i_cfg_data;
                    chrp_pkg::REG_OUTER_KI:    r_oki  <= i_cfg_data;
                    chrp_pkg::REG_OUTER_KD:    r_okd  <= i_cfg_data;
                    chrp_pkg::REG_OUTER_LIMIT: r_olim <= i_cfg_data[30:0];
                    chrp_pkg::REG_INNER_KP:    r_ikp  <= i_cfg_data;
                    chrp_pkg::REG_INNER_KI:    r_iki  <= i_cfg_data;
                    chrp_pkg::REG_INNER_KD:    r_ikd  <= i_cfg_data;
                    chrp_pkg::REG_INNER_LIMIT: r_ilim <= i_cfg_data[30:0];
                    default: ;
                endcase
            end
        end
    end

    // Payload and working registers.
    always_ff @(posedge i_clk) begin
        if (r_st == chrp_pkg::S_IDLE && i_in_valid) begin
            r_angle <= i_heading_angle; r_gyro <= i_gyro_rate;
            r_tgt <= i_target_angle; r_shift <= i_target_shift;
            r_acro <= i_acro_mode; r_manual <= i_manual_rate;
        end
        r_unw <= n_unw; r_ts <= n_ts; r_oerr <= n_oerr; r_p <= n_p; r_d <= n_d;
        r_rref <= n_rref; r_ierr <= n_ierr; r_facc <= n_facc; r_cap <= n_cap;
        r_mp <= n_mp; r_mc <= n_mc; r_ah <= n_ah; r_al <= n_al; r_cnt <= n_cnt;
        if (load_out) begin
            r_o_drive <= chrp_pkg::clamp_sym(50'(r_fo), r_ilim);
            r_o_rref  <= r_rref;
            r_o_unw   <= r_unw;
            r_o_cap   <= r_cap;
        end
    end

endmodule

// ----- tb/cascaded_heading_rate_pid_core_tb.sv -----
// Testbench for the cascaded heading and rate controller core.
// Predicts each tick in its own model and checks every result; needs chrp_pkg and the core.
`timescale 1ns / 1ps

module cascaded_heading_rate_pid_core_tb;

    localparam int FF_GAIN = 0;

    typedef struct {
        logic signed [18:0] angle;
        logic signed [31:0] gyro;
        logic signed [31:0] target;
        logic signed [31:0] shift;
        logic               acro;
        logic signed [31:0] manual;
    } t_tick;

    typedef struct {
        logic signed [31:0] drive;
        logic signed [31:0] rate;
        logic signed [31:0] unwrapped;
        logic               captured;
    } t_drive;

    typedef struct {
        t_tick  tick;
        bit     typed;
        t_drive want;
    } t_row;

    logic               i_clk;
    logic               i_rst_n;
    logic               i_in_valid;
    logic               o_in_stall;
    logic signed [18:0] i_heading_angle;
    logic signed [31:0] i_gyro_rate;
    logic signed [31:0] i_target_angle;
    logic signed [31:0] i_target_shift;
    logic               i_acro_mode;
    logic signed [31:0] i_manual_rate;
    logic               o_out_valid;
    logic               i_out_stall;
    logic signed [31:0] o_drive_output;
    logic signed [31:0] o_rate_target;
    logic signed [31:0] o_unwrapped_angle;
    logic               o_reference_captured;
    logic               i_cfg_valid;
    logic               o_cfg_ready;
    logic [2:0]         i_cfg_index;
    logic [31:0]        i_cfg_data;

    cascaded_heading_rate_pid_core #(
        .FEEDFORWARD_GAIN_Q16(FF_GAIN)
    ) u_dut (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_in_valid(i_in_valid), .o_in_stall(o_in_stall),
        .i_heading_angle(i_heading_angle), .i_gyro_rate(i_gyro_rate),
        .i_target_angle(i_target_angle), .i_target_shift(i_target_shift),
        .i_acro_mode(i_acro_mode), .i_manual_rate(i_manual_rate),
        .o_out_valid(o_out_valid), .i_out_stall(i_out_stall),
        .o_drive_output(o_drive_output), .o_rate_target(o_rate_target),
        .o_unwrapped_angle(o_unwrapped_angle),
        .o_reference_captured(o_reference_captured),
        .i_cfg_valid(i_cfg_valid), .o_cfg_ready(o_cfg_ready),
        .i_cfg_index(i_cfg_index), .i_cfg_data(i_cfg_data)
    );

    // Clock with an 8 ns period.
    initial begin
        i_clk = 1'b0;
    end
    always begin
        #4 i_clk = 1'b1;
        #4 i_clk = 1'b0;
    end

    // Controller state as the predictor sees it.
    logic [31:0] gains [8];
    longint      turns, last_angle, o_prev_err, o_integ, o_hold;
    longint      i_prev_err, i_integ, lpf_state;
    bit          acro_seen;

    t_drive      pending_q [$];
    int          mismatches;
    bit          quiet;
    bit          hold_request;

    function automatic longint sat(input longint x);
        if (x > 64'sd2147483647) return 64'sd2147483647;
        if (x < -64'sd2147483648) return -64'sd2147483648;
        return x;
    endfunction

    function automatic longint limit_to(input longint x, input logic [30:0] lim);
        longint l;
        l = longint'(lim);
        if (x > l) return l;
        if (x < -l) return -l;
        return x;
    endfunction

    function automatic longint gain_times(input logic [31:0] g, input longint v);
        return sat((longint'(g) * v) >>> 16);
    endfunction

    // One PID stage: updates the integral, returns the unclamped sum.
    function automatic longint pid_sum(input logic [31:0] kp, input logic [31:0] ki,
                                       input logic [31:0] kd, input longint err,
                                       input longint prev, inout longint integ);
        longint p;
        longint d;
        p = gain_times(kp, err);
        d = gain_times(kd, sat(err - prev));
        integ = sat(integ + gain_times(ki, err));
        return p + integ + d;
    endfunction

    // Turn count the next tick would use, without changing any state.
    function automatic longint next_turns(input longint ang);
        longint delta;
        delta = ang - last_angle;
        if (delta < -chrp_pkg::PI_Q16 && turns < 127) return turns + 1;
        if (delta > chrp_pkg::PI_Q16 && turns > -128) return turns - 1;
        return turns;
    endfunction

    function automatic longint next_unwrapped(input longint ang);
        return sat(next_turns(ang) * chrp_pkg::TWO_PI_Q16 + ang);
    endfunction

    // Full tick of the controller, updating the predictor state.
    function automatic t_drive predict_tick(input t_tick t);
        t_drive r;
        longint ang, unw, oerr, rate, ierr, s, ff, vi;
        ang = longint'(t.angle);
        turns = next_turns(ang);
        unw = sat(turns * chrp_pkg::TWO_PI_Q16 + ang);
        last_angle = ang;
        r.captured = 1'b0;
        r.unwrapped = 32'(unw);

        // Angle loop with deadband hold.
        oerr = sat(sat(longint'(t.target) - longint'(t.shift)) - unw);
        if (oerr >= -chrp_pkg::DEADBAND_Q16 && oerr <= chrp_pkg::DEADBAND_Q16) begin
            o_prev_err = oerr;
        end else begin
            s = pid_sum(gains[chrp_pkg::REG_OUTER_KP], gains[chrp_pkg::REG_OUTER_KI],
                        gains[chrp_pkg::REG_OUTER_KD], oerr, o_prev_err, o_integ);
            o_hold = limit_to(s, gains[chrp_pkg::REG_OUTER_LIMIT][30:0]);
            o_prev_err = oerr;
        end

        // Rate reference: angle loop or manual stick.
        if (!t.acro) begin
            if (acro_seen) begin
                o_hold = 0;
                turns = 0;
                acro_seen = 1'b0;
                r.captured = 1'b1;
            end
            rate = o_hold;
        end else begin
            rate = sat((-longint'(t.manual)) >>> 1);
            acro_seen = 1'b1;
        end

        // Rate loop, feedforward, low-pass and output clamp.
        ierr = sat(rate - longint'(t.gyro));
        s = pid_sum(gains[chrp_pkg::REG_INNER_KP], gains[chrp_pkg::REG_INNER_KI],
                    gains[chrp_pkg::REG_INNER_KD], ierr, i_prev_err, i_integ);
        ff = (rate * FF_GAIN) >>> 16;
        vi = sat(s + sat(ff));
        lpf_state = sat((longint'(chrp_pkg::LPF_IN_COEF) * vi +
                         longint'(chrp_pkg::LPF_FB_COEF) * lpf_state) >>> 16);
        i_prev_err = ierr;
        r.drive = 32'(limit_to(lpf_state, gains[chrp_pkg::REG_INNER_LIMIT][30:0]));
        r.rate = 32'(rate);
        return r;
    endfunction

    function automatic t_tick make_tick(input int ang, input int gyro, input int tgt,
                                        input int sh, input bit acro, input int man);
        t_tick t;
        t.angle = 19'(ang);
        t.gyro = gyro;
        t.target = tgt;
        t.shift = sh;
        t.acro = acro;
        t.manual = man;
        return t;
    endfunction

    function automatic t_row make_row(input t_tick t, input bit typed, input int drv,
                                      input int rate, input int unw, input bit cap);
        t_row r;
        r.tick = t;
        r.typed = typed;
        r.want.drive = drv;
        r.want.rate = rate;
        r.want.unwrapped = unw;
        r.want.captured = cap;
        return r;
    endfunction

    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (quiet || r < 60) return 0;
        if (r < 92) return $urandom_range(1, 3);
        return $urandom_range(10, 60);
    endfunction

    // Offer one request and wait until it is taken; returns the predicted result.
    task automatic send_tick(input t_tick t, output t_drive predicted);
        int gap;
        i_in_valid <= 1'b1;
        i_heading_angle <= t.angle;
        i_gyro_rate <= t.gyro;
        i_target_angle <= t.target;
        i_target_shift <= t.shift;
        i_acro_mode <= t.acro;
        i_manual_rate <= t.manual;
        do @(posedge i_clk); while (o_in_stall);
        predicted = predict_tick(t);
        gap = pick_gap();
        if (gap > 0) begin
            i_in_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
    endtask

    task automatic send_checked(input t_tick t);
        t_drive p;
        send_tick(t, p);
        pending_q.push_back(p);
    endtask

    // Stops offering requests and waits until every result has come back.
    task automatic wait_idle();
        i_in_valid <= 1'b0;
        while (pending_q.size() != 0) @(posedge i_clk);
        repeat (8) @(posedge i_clk);
    endtask

    // Writes a full set of gains and limits; the channel stays high between writes.
    task automatic load_gains(input logic [31:0] vals [8]);
        for (int k = 0; k < 8; k++) begin
            i_cfg_valid <= 1'b1;
            i_cfg_index <= 3'(k);
            i_cfg_data <= vals[k];
            do @(posedge i_clk); while (!o_cfg_ready);
            gains[k] = vals[k];
        end
        i_cfg_valid <= 1'b0;
        @(posedge i_clk);
    endtask

    task automatic load_random_gains();
        logic [31:0] v [8];
        for (int k = 0; k < 8; k++) begin
            if ($urandom_range(0, 5) == 0) v[k] = $urandom;
            else v[k] = $urandom_range(0, 32'h0003_0000);
        end
        if ($urandom_range(0, 1) == 1) v[chrp_pkg::REG_OUTER_LIMIT] = $urandom;
        if ($urandom_range(0, 1) == 1) v[chrp_pkg::REG_INNER_LIMIT] = $urandom;
        load_gains(v);
    endtask

    // Spins the heading a number of whole turns, three requests per turn.
    task automatic spin(input int wraps, input bit upward, input bit near_target);
        int a;
        longint u;
        for (int w = 0; w < wraps; w++) begin
            for (int ph = 0; ph < 3; ph++) begin
                a = (ph == 0) ? 0 : 150000 + $urandom_range(0, 40000);
                if ((ph == 2) == upward) a = -a;
                u = next_unwrapped(a);
                send_checked(make_tick(a, $urandom_range(0, 4000) - 2000,
                                       near_target ? 32'(u + $urandom_range(0, 4000) - 2000)
                                                   : $urandom,
                                       0, 1'b0, $urandom));
            end
        end
    endtask

    // Result checking against the oldest prediction.
    always @(posedge i_clk) begin
        t_drive w;
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            if (pending_q.size() == 0) begin
                mismatches++;
                if (mismatches <= 10) $display("Unexpected result at %0t", $realtime);
            end else begin
                w = pending_q.pop_front();
                if (w.drive !== o_drive_output || w.rate !== o_rate_target ||
                    w.unwrapped !== o_unwrapped_angle ||
                    w.captured !== o_reference_captured) begin
                    mismatches++;
                    if (mismatches <= 10) begin
                        $display("Mismatch at %0t: expected %0d %0d %0d %0b, got %0d %0d %0d %0b",
                                 $realtime, w.drive, w.rate, w.unwrapped, w.captured,
                                 o_drive_output, o_rate_target, o_unwrapped_angle,
                                 o_reference_captured);
                    end
                end
            end
        end
    end

    // Receiver: random stalls, quiet stretches and long hold-offs on request.
    initial begin
        i_out_stall = 1'b0;
        forever begin
            int r;
            r = $urandom_range(0, 99);
            if (hold_request) begin
                i_out_stall <= 1'b1;
                repeat (2000) @(posedge i_clk);
                hold_request = 1'b0;
            end else if (quiet || r < 60) begin
                i_out_stall <= 1'b0;
                repeat ($urandom_range(1, 20)) @(posedge i_clk);
            end else if (r < 92) begin
                i_out_stall <= 1'b1;
                repeat ($urandom_range(1, 4)) @(posedge i_clk);
            end else begin
                i_out_stall <= 1'b1;
                repeat ($urandom_range(20, 80)) @(posedge i_clk);
            end
        end
    end

    // Run limit.
    initial begin
        #20000000;
        $display("Verification failed");
        $finish;
    end

    // Main stimulus.
    initial begin
        t_row        rows [$];
        logic [31:0] v [8];
        t_drive      p;
        t_tick       t;
        int          sent;
        int          kind;
        int          n;
        int          a;
        longint      u;

        i_rst_n = 1'b0;
        i_in_valid = 1'b0;
        i_heading_angle = '0;
        i_gyro_rate = '0;
        i_target_angle = '0;
        i_target_shift = '0;
        i_acro_mode = 1'b0;
        i_manual_rate = '0;
        i_cfg_valid = 1'b0;
        i_cfg_index = '0;
        i_cfg_data = '0;
        mismatches = 0;
        quiet = 1'b0;
        hold_request = 1'b0;
        for (int k = 0; k < 8; k++) gains[k] = '0;
        turns = 0; last_angle = 0; o_prev_err = 0; o_integ = 0; o_hold = 0;
        i_prev_err = 0; i_integ = 0; lpf_state = 0; acro_seen = 1'b0;

        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // With all gains zero after reset the drive stays zero and the other fields read off.
        rows.push_back(make_row(make_tick(0, 0, 0, 0, 0, 0), 1, 0, 0, 0, 0));
        rows.push_back(make_row(make_tick(205887, 0, 0, 0, 0, 0), 1, 0, 0, 205887, 0));
        rows.push_back(make_row(make_tick(-205887, 0, 0, 0, 0, 0), 1, 0, 0, 205888, 0));
        rows.push_back(make_row(make_tick(-205887, 0, 0, 0, 1, 32'h8000_0000),
                                1, 0, 32'h4000_0000, 205888, 0));
        rows.push_back(make_row(make_tick(-205887, 0, 0, 0, 0, 0), 1, 0, 0, 205888, 1));
        rows.push_back(make_row(make_tick(0, 0, 0, 0, 1, 32'h7FFF_FFFF),
                                1, 0, 32'hC000_0000, 0, 0));
        rows.push_back(make_row(make_tick(0, 0, 0, 0, 0, 0), 1, 0, 0, 0, 1));
        foreach (rows[k]) begin
            send_tick(rows[k].tick, p);
            pending_q.push_back(rows[k].want);
        end
        wait_idle();

        // Moderate gains, then deadband edges, saturation and out-of-range headings.
        v = '{32'h0001_0000, 32'h0000_4000, 32'h0000_8000, 32'h0010_0000,
              32'h0002_0000, 32'h0000_2000, 32'h0000_1000, 32'h0008_0000};
        load_gains(v);
        rows.delete();
        rows.push_back(make_row(make_tick(0, 0, 655, 0, 0, 0), 0, 0, 0, 0, 0));
        rows.push_back(make_row(make_tick(0, 0, 656, 0, 0, 0), 0, 0, 0, 0, 0));
        rows.push_back(make_row(make_tick(0, 0, -655, 0, 0, 0), 0, 0, 0, 0, 0));
        rows.push_back(make_row(make_tick(0, 0, -656, 0, 0, 0), 0, 0, 0, 0, 0));
        rows.push_back(make_row(make_tick(0, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h8000_0000,
                                          0, 0), 0, 0, 0, 0, 0));
        rows.push_back(make_row(make_tick(0, 32'h8000_0000, 32'h8000_0000, 32'h7FFF_FFFF,
                                          1, 32'h8000_0000), 0, 0, 0, 0, 0));
        rows.push_back(make_row(make_tick(262143, 0, 0, 0, 0, 0), 0, 0, 0, 0, 0));
        rows.push_back(make_row(make_tick(-262144, 0, 0, 0, 0, 0), 0, 0, 0, 0, 0));
        rows.push_back(make_row(make_tick(-262144, -1, 0, 0, 1, -1), 0, 0, 0, 0, 0));
        foreach (rows[k]) send_checked(rows[k].tick);
        wait_idle();

        // Extreme gains and limits, then everything zeroed again.
        for (int k = 0; k < 8; k++) v[k] = 32'hFFFF_FFFF;
        load_gains(v);
        for (int k = 0; k < 4; k++) begin
            send_checked(make_tick($urandom, $urandom, $urandom, $urandom, k[0], $urandom));
        end
        wait_idle();
        for (int k = 0; k < 8; k++) v[k] = '0;
        load_gains(v);
        send_checked(make_tick(1000, 77, 500000, 0, 0, 0));
        wait_idle();
        load_random_gains();

        // Random part: well-formed segments with random content, plus some noise.
        sent = 0;
        while (sent < 126) begin
            kind = $urandom_range(0, 99);
            if (sent >= 40 && sent < 90) hold_request = 1'b1;
            quiet = (sent > 90 && sent < 120);
            if (kind < 20) begin
                n = $urandom_range(3, 15);
                spin(n, $urandom_range(0, 1), $urandom_range(0, 1));
                sent += 3 * n;
            end else if (kind < 55) begin
                // Heading hold near the reference, often inside the deadband.
                n = $urandom_range(5, 20);
                for (int k = 0; k < n; k++) begin
                    a = $urandom_range(0, 411774) - 205887;
                    u = next_unwrapped(a);
                    u += ($urandom_range(0, 1) == 1) ? $urandom_range(0, 1400) - 700
                                                      : $urandom_range(0, 200000) - 100000;
                    t = make_tick(a, $urandom_range(0, 400000) - 200000, 0, 0, 1'b0,
                                  $urandom);
                    t.shift = $urandom_range(0, 100000) - 50000;
                    t.target = 32'(sat(u + longint'(t.shift)));
                    send_checked(t);
                end
                sent += n;
            end else if (kind < 75) begin
                // Acro stretch followed by a return to heading hold.
                n = $urandom_range(1, 8);
                for (int k = 0; k <= n; k++) begin
                    send_checked(make_tick($urandom_range(0, 411774) - 205887, $urandom,
                                           $urandom, $urandom, k < n, $urandom));
                end
                sent += n + 1;
            end else if (kind < 95) begin
                n = $urandom_range(3, 10);
                for (int k = 0; k < n; k++) begin
                    send_checked(make_tick($urandom, $urandom, $urandom, $urandom,
                                           $urandom_range(0, 1), $urandom));
                end
                sent += n;
            end else begin
                wait_idle();
                load_random_gains();
            end
        end
        quiet = 1'b0;

        // Clear the turn count by leaving acro, saturate it upwards, then clear it again.
        wait_idle();
        load_random_gains();
        send_checked(make_tick(0, 0, 0, 0, 1, $urandom));
        send_checked(make_tick(0, 0, 0, 0, 0, 0));
        spin(130, 1'b1, 1'b1);
        spin(1, 1'b1, 1'b0);
        send_checked(make_tick(0, 0, 0, 0, 1, $urandom));
        send_checked(make_tick(0, 0, 0, 0, 0, 0));
        spin(2, 1'b0, 1'b1);

        i_in_valid <= 1'b0;
        n = 0;
        while (pending_q.size() != 0 && n < 200000) begin
            @(posedge i_clk);
            n++;
        end
        repeat (400) @(posedge i_clk);
        if (mismatches == 0 && pending_q.size() == 0) begin
            $display("Verification passed");
        end else begin
            $display("Verification failed");
        end
        $finish;
    end

endmodule
